FILE: hdl/message_arq_sender_defines.svh
// assertion macros for the message sender block
// no dependencies; included by the top level before its assertions
`ifndef MESSAGE_ARQ_SENDER_DEFINES_SVH
`define MESSAGE_ARQ_SENDER_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define MAS_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("message_arq_sender: check failed");

// consequent must hold at the edge where the antecedent holds
`define MAS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("message_arq_sender: check failed");

`endif

FILE: hdl/mas_pkg.sv
// types and constants for the stop-and-wait message sender
// no dependencies; used by message_arq_sender
package mas_pkg;

  localparam int unsigned AddrW   = 16;
  localparam int unsigned MsgW    = 8;
  localparam int unsigned TickW   = 16;
  localparam int unsigned RetryW  = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 48;
  localparam int unsigned OutUserW = 2;

  // register reset values
  localparam logic [AddrW-1:0]  RadioIdRst     = 16'd1;
  localparam logic [AddrW-1:0]  BcastIdRst     = 16'hFFFF;
  localparam logic [TickW-1:0]  AckTimeoutRst  = 16'd100;
  localparam logic [TickW-1:0]  BcastGapRst    = 16'd50;
  localparam logic [RetryW-1:0] MaxRetriesRst  = 8'd3;
  localparam logic [TickW-1:0]  OkHoldRst      = 16'd100;
  localparam logic [TickW-1:0]  FailHoldRst    = 16'd150;

  typedef enum logic [2:0] {
    ACT_TICK   = 3'd0,
    ACT_SEND   = 3'd1,
    ACT_CANCEL = 3'd2,
    ACT_ACK    = 3'd3,
    ACT_DATA   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_SENDING  = 3'd1,
    PH_BC_GAP   = 3'd2,
    PH_WAIT_ACK = 3'd3,
    PH_ACKED    = 3'd4,
    PH_FAILED   = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    TX_NONE  = 2'd0,
    TX_ACK   = 2'd1,
    TX_UNI   = 2'd2,
    TX_BCAST = 2'd3
  } tx_kind_e;

  typedef enum logic [1:0] {
    NOTE_NONE = 2'd0,
    NOTE_OK   = 2'd1,
    NOTE_FAIL = 2'd2
  } notice_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RADIO_ID    = 3'd0,
    REG_BCAST_ID    = 3'd1,
    REG_ACK_TIMEOUT = 3'd2,
    REG_BCAST_GAP   = 3'd3,
    REG_MAX_RETRIES = 3'd4,
    REG_OK_HOLD     = 3'd5,
    REG_FAIL_HOLD   = 3'd6
  } reg_idx_e;

  // one received request, unpacked
  typedef struct packed {
    logic [2:0]       action;
    logic             broadcast;
    logic [AddrW-1:0] dest_id;
    logic [AddrW-1:0] frame_sender_id;
    logic [AddrW-1:0] frame_receiver_id;
    logic [MsgW-1:0]  frame_message_id;
  } req_t;

  // one result, unpacked
  typedef struct packed {
    tx_kind_e         tx_kind;
    logic [AddrW-1:0] tx_sender_id;
    logic [AddrW-1:0] tx_receiver_id;
    logic [MsgW-1:0]  tx_message_id;
    phase_e           send_state;
    notice_e          notice;
    logic             rx_for_me;
  } res_t;

endpackage

FILE: hdl/message_arq_sender.sv
// stop-and-wait message sender with ack matching, top level
// depends on mas_pkg and message_arq_sender_defines.svh
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           tuser: action, broadcast; tdata: ids, msg id
//   m_axis    out  tvalid/tready           tuser: tx_kind; tdata: frame, state, notice
//   cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// one request per cycle while results are taken; a request passes the
// input register, then the decision logic into the result register
// the result register frees as it is taken, so a stalled output holds one
// result plus one request in the input register before tready drops
// reset clears all sender state and loads the register defaults

`include "message_arq_sender_defines.svh"

module message_arq_sender (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [15:0] dest_id, [31:16] frame_sender_id, [47:32] frame_receiver_id,
  // [55:48] frame_message_id
  input  logic [mas_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] action, [3] broadcast
  input  logic [mas_pkg::InUserW-1:0]   s_axis_tuser,
  // result channel
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] tx_sender_id, [31:16] tx_receiver_id, [39:32] tx_message_id,
  // [42:40] send_state, [44:43] notice, [45] rx_for_me, [47:46] zero
  output logic [mas_pkg::OutDataW-1:0]  m_axis_tdata,
  // [1:0] tx_kind
  output logic [mas_pkg::OutUserW-1:0]  m_axis_tuser,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [mas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mas_pkg::CfgW-1:0]      cfg_data_i
);

  // configuration registers
  logic [mas_pkg::AddrW-1:0]  radio_id_q, bcast_id_q;
  logic [mas_pkg::TickW-1:0]  ack_timeout_q, bcast_gap_q, ok_hold_q, fail_hold_q;
  logic [mas_pkg::RetryW-1:0] max_retries_q;

  // pipeline registers
  logic            in_valid_q, out_valid_q;
  mas_pkg::req_t   req_q;
  mas_pkg::res_t   res_q, res_d;
  logic            advance;

  // sender state
  mas_pkg::phase_e            phase_q, phase_d;
  logic                       screen_q, screen_d;
  logic [mas_pkg::TickW-1:0]  cd_q, cd_d;
  logic [mas_pkg::RetryW-1:0] retries_q, retries_d;
  logic                       repeats_q, repeats_d;
  logic                       is_bcast_q, is_bcast_d;
  logic [mas_pkg::AddrW-1:0]  pend_snd_q, pend_snd_d;
  logic [mas_pkg::AddrW-1:0]  pend_rcv_q, pend_rcv_d;
  logic [mas_pkg::MsgW-1:0]   pend_msg_q, pend_msg_d;
  logic [mas_pkg::MsgW-1:0]   next_msg_q, next_msg_d;
  logic                       ackq_q, ackq_d;
  logic [mas_pkg::AddrW-1:0]  ack_tgt_q, ack_tgt_d;
  logic [mas_pkg::MsgW-1:0]   ack_msg_q, ack_msg_d;

  logic                       cd_expired;
  logic [mas_pkg::TickW-1:0]  cd_dec;
  logic                       ack_match;

  // handshake: a request moves on when the result slot is free or draining
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  // configuration port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radio_id_q    <= mas_pkg::RadioIdRst;
      bcast_id_q    <= mas_pkg::BcastIdRst;
      ack_timeout_q <= mas_pkg::AckTimeoutRst;
      bcast_gap_q   <= mas_pkg::BcastGapRst;
      max_retries_q <= mas_pkg::MaxRetriesRst;
      ok_hold_q     <= mas_pkg::OkHoldRst;
      fail_hold_q   <= mas_pkg::FailHoldRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mas_pkg::REG_RADIO_ID:    radio_id_q    <= cfg_data_i;
        mas_pkg::REG_BCAST_ID:    bcast_id_q    <= cfg_data_i;
        mas_pkg::REG_ACK_TIMEOUT: ack_timeout_q <= cfg_data_i;
        mas_pkg::REG_BCAST_GAP:   bcast_gap_q   <= cfg_data_i;
        mas_pkg::REG_MAX_RETRIES: max_retries_q <= cfg_data_i[mas_pkg::RetryW-1:0];
        mas_pkg::REG_OK_HOLD:     ok_hold_q     <= cfg_data_i;
        mas_pkg::REG_FAIL_HOLD:   fail_hold_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_q.action            <= s_axis_tuser[2:0];
      req_q.broadcast         <= s_axis_tuser[3];
      req_q.dest_id           <= s_axis_tdata[15:0];
      req_q.frame_sender_id   <= s_axis_tdata[31:16];
      req_q.frame_receiver_id <= s_axis_tdata[47:32];
      req_q.frame_message_id  <= s_axis_tdata[55:48];
    end
  end

  // shared countdown: at one or zero it runs out on this tick
  assign cd_expired = (cd_q <= mas_pkg::TickW'(1));
  assign cd_dec     = cd_expired ? '0 : cd_q - mas_pkg::TickW'(1);

  assign ack_match = (phase_q == mas_pkg::PH_WAIT_ACK) &&
                     (req_q.frame_receiver_id == pend_snd_q) &&
                     (req_q.frame_sender_id == pend_rcv_q) &&
                     (req_q.frame_message_id == pend_msg_q);

  // request decision and next state
  always_comb begin
    phase_d    = phase_q;
    screen_d   = screen_q;
    cd_d       = cd_q;
    retries_d  = retries_q;
    repeats_d  = repeats_q;
    is_bcast_d = is_bcast_q;
    pend_snd_d = pend_snd_q;
    pend_rcv_d = pend_rcv_q;
    pend_msg_d = pend_msg_q;
    next_msg_d = next_msg_q;
    ackq_d     = ackq_q;
    ack_tgt_d  = ack_tgt_q;
    ack_msg_d  = ack_msg_q;

    res_d                = '0;
    res_d.tx_kind        = mas_pkg::TX_NONE;
    res_d.notice         = mas_pkg::NOTE_NONE;

    unique case (req_q.action)
      mas_pkg::ACT_TICK: begin
        if (ackq_q) begin
          // a queued ack takes the tick ahead of the sender
          ackq_d               = 1'b0;
          res_d.tx_kind        = mas_pkg::TX_ACK;
          res_d.tx_sender_id   = radio_id_q;
          res_d.tx_receiver_id = ack_tgt_q;
          res_d.tx_message_id  = ack_msg_q;
        end else begin
          unique case (phase_q)
            mas_pkg::PH_SENDING: begin
              res_d.tx_kind        = is_bcast_q ? mas_pkg::TX_BCAST : mas_pkg::TX_UNI;
              res_d.tx_sender_id   = pend_snd_q;
              res_d.tx_receiver_id = pend_rcv_q;
              res_d.tx_message_id  = pend_msg_q;
              if (is_bcast_q) begin
                if (repeats_q) begin
                  repeats_d = 1'b0;
                  cd_d      = bcast_gap_q;
                  phase_d   = mas_pkg::PH_BC_GAP;
                end else begin
                  phase_d      = mas_pkg::PH_ACKED;
                  cd_d         = ok_hold_q;
                  res_d.notice = mas_pkg::NOTE_OK;
                end
              end else begin
                cd_d    = ack_timeout_q;
                phase_d = mas_pkg::PH_WAIT_ACK;
              end
            end
            mas_pkg::PH_BC_GAP: begin
              cd_d = cd_dec;
              if (cd_expired) phase_d = mas_pkg::PH_SENDING;
            end
            mas_pkg::PH_WAIT_ACK: begin
              cd_d = cd_dec;
              if (cd_expired) begin
                if (retries_q != '0) begin
                  retries_d = retries_q - mas_pkg::RetryW'(1);
                  phase_d   = mas_pkg::PH_SENDING;
                end else begin
                  phase_d      = mas_pkg::PH_FAILED;
                  cd_d         = fail_hold_q;
                  res_d.notice = mas_pkg::NOTE_FAIL;
                end
              end
            end
            mas_pkg::PH_ACKED, mas_pkg::PH_FAILED: begin
              // result hold counts only while the screen is open
              if (screen_q) begin
                cd_d = cd_dec;
                if (cd_expired) begin
                  screen_d = 1'b0;
                  phase_d  = mas_pkg::PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      mas_pkg::ACT_SEND: begin
        pend_snd_d = radio_id_q;
        pend_rcv_d = req_q.broadcast ? bcast_id_q : req_q.dest_id;
        pend_msg_d = next_msg_q;
        next_msg_d = next_msg_q + mas_pkg::MsgW'(1);
        is_bcast_d = req_q.broadcast;
        retries_d  = max_retries_q;
        repeats_d  = req_q.broadcast;
        phase_d    = mas_pkg::PH_SENDING;
        screen_d   = 1'b1;
      end
      mas_pkg::ACT_CANCEL: begin
        if (screen_q) begin
          phase_d  = mas_pkg::PH_IDLE;
          screen_d = 1'b0;
        end
      end
      mas_pkg::ACT_ACK: begin
        if (ack_match) begin
          phase_d      = mas_pkg::PH_ACKED;
          cd_d         = ok_hold_q;
          res_d.notice = mas_pkg::NOTE_OK;
        end
      end
      mas_pkg::ACT_DATA: begin
        if (req_q.broadcast || (req_q.frame_receiver_id == radio_id_q)) begin
          res_d.rx_for_me = 1'b1;
          if (!req_q.broadcast) begin
            ack_tgt_d = req_q.frame_sender_id;
            ack_msg_d = req_q.frame_message_id;
            ackq_d    = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res_d.send_state = phase_d;
  end

  // sender state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mas_pkg::PH_IDLE;
      screen_q   <= 1'b0;
      cd_q       <= '0;
      retries_q  <= '0;
      repeats_q  <= 1'b0;
      is_bcast_q <= 1'b0;
      pend_snd_q <= '0;
      pend_rcv_q <= '0;
      pend_msg_q <= '0;
      next_msg_q <= '0;
      ackq_q     <= 1'b0;
      ack_tgt_q  <= '0;
      ack_msg_q  <= '0;
    end else if (advance) begin
      phase_q    <= phase_d;
      screen_q   <= screen_d;
      cd_q       <= cd_d;
      retries_q  <= retries_d;
      repeats_q  <= repeats_d;
      is_bcast_q <= is_bcast_d;
      pend_snd_q <= pend_snd_d;
      pend_rcv_q <= pend_rcv_d;
      pend_msg_q <= pend_msg_d;
      next_msg_q <= next_msg_d;
      ackq_q     <= ackq_d;
      ack_tgt_q  <= ack_tgt_d;
      ack_msg_q  <= ack_msg_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = res_q.tx_kind;
  assign m_axis_tdata  = {2'd0, res_q.rx_for_me, res_q.notice, res_q.send_state,
                          res_q.tx_message_id, res_q.tx_receiver_id, res_q.tx_sender_id};

  // checks
  `MAS_ASSERT_ALWAYS(a_screen_tracks_phase, screen_q == (phase_q != mas_pkg::PH_IDLE))
  `MAS_ASSERT_IMPLY(a_notice_state, out_valid_q && (res_q.notice != mas_pkg::NOTE_NONE),
    (res_q.send_state == mas_pkg::PH_ACKED) || (res_q.send_state == mas_pkg::PH_FAILED))
  `MAS_ASSERT_IMPLY(a_idle_frame_zero, out_valid_q && (res_q.tx_kind == mas_pkg::TX_NONE),
    (res_q.tx_sender_id == '0) && (res_q.tx_receiver_id == '0) && (res_q.tx_message_id == '0))
  `MAS_ASSERT_IMPLY(a_rx_no_tx, out_valid_q && res_q.rx_for_me,
    (res_q.tx_kind == mas_pkg::TX_NONE) && (res_q.notice == mas_pkg::NOTE_NONE))

endmodule

FILE: test/tb_message_arq_sender.sv
// testbench for message_arq_sender: directed and random requests, timer settings swept
// depends on mas_pkg and the message_arq_sender rtl; results checked against a local predictor
`timescale 1ns / 100ps

module tb_message_arq_sender;

  localparam int unsigned StuckLimit = 3000;
  localparam logic [2:0] ActReservedLo = 3'd5;
  localparam logic [2:0] ActReservedHi = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mas_pkg::InDataW-1:0] s_axis_tdata = '0;
  logic [mas_pkg::InUserW-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mas_pkg::OutDataW-1:0] m_axis_tdata;
  logic [mas_pkg::OutUserW-1:0] m_axis_tuser;
  logic cfg_we_i = 1'b0;
  logic [mas_pkg::CfgIdxW-1:0] cfg_idx_i = mas_pkg::REG_RADIO_ID;
  logic [mas_pkg::CfgW-1:0] cfg_data_i = '0;

  message_arq_sender dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // predictor copy of the register file
  logic [15:0] my_addr, bc_addr, ack_ticks, gap_ticks, ok_ticks, fail_ticks;
  logic [7:0]  retry_lim;

  // predictor copy of the sender state
  mas_pkg::phase_e ph;
  bit          screen_up, repeat_pending, bc_send, ack_owed, seq_wrapped;
  logic [15:0] tick_cnt, pend_src, pend_dst, ack_dst;
  logic [7:0]  retries_rem, pend_msg, msg_seq, ack_seq;

  mas_pkg::res_t frames_due[$];
  int   err_count = 0;
  int   stuck_cycles = 0;
  bit   no_idle = 1'b0;
  int   stall_left = 0;
  int   stall_roll;

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    err_count++;
    $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
  endtask

  task automatic sender_reset();
    my_addr = mas_pkg::RadioIdRst;
    bc_addr = mas_pkg::BcastIdRst;
    ack_ticks = mas_pkg::AckTimeoutRst;
    gap_ticks = mas_pkg::BcastGapRst;
    retry_lim = mas_pkg::MaxRetriesRst;
    ok_ticks = mas_pkg::OkHoldRst;
    fail_ticks = mas_pkg::FailHoldRst;
    ph = mas_pkg::PH_IDLE;
    screen_up = 1'b0;
    tick_cnt = '0;
    retries_rem = '0;
    repeat_pending = 1'b0;
    bc_send = 1'b0;
    pend_src = '0;
    pend_dst = '0;
    pend_msg = '0;
    msg_seq = '0;
    ack_owed = 1'b0;
    ack_dst = '0;
    ack_seq = '0;
    seq_wrapped = 1'b0;
  endtask

  // shared countdown; zero counts as already expired
  function automatic bit tick_down();
    if (tick_cnt <= 16'd1) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = tick_cnt - 16'd1;
    return 1'b0;
  endfunction

  // expected result of one request, advancing the sender state
  function automatic mas_pkg::res_t predict_step(input mas_pkg::req_t r);
    mas_pkg::res_t o;
    o = '0;
    case (r.action)
      mas_pkg::ACT_TICK: begin
        if (ack_owed) begin
          // queued ack goes out ahead of the sender
          ack_owed = 1'b0;
          o.tx_kind = mas_pkg::TX_ACK;
          o.tx_sender_id = my_addr;
          o.tx_receiver_id = ack_dst;
          o.tx_message_id = ack_seq;
        end else begin
          case (ph)
            mas_pkg::PH_SENDING: begin
              o.tx_kind = bc_send ? mas_pkg::TX_BCAST : mas_pkg::TX_UNI;
              o.tx_sender_id = pend_src;
              o.tx_receiver_id = pend_dst;
              o.tx_message_id = pend_msg;
              if (bc_send) begin
                if (repeat_pending) begin
                  repeat_pending = 1'b0;
                  tick_cnt = gap_ticks;
                  ph = mas_pkg::PH_BC_GAP;
                end else begin
                  ph = mas_pkg::PH_ACKED;
                  tick_cnt = ok_ticks;
                  o.notice = mas_pkg::NOTE_OK;
                end
              end else begin
                tick_cnt = ack_ticks;
                ph = mas_pkg::PH_WAIT_ACK;
              end
            end
            mas_pkg::PH_BC_GAP: begin
              if (tick_down()) ph = mas_pkg::PH_SENDING;
            end
            mas_pkg::PH_WAIT_ACK: begin
              if (tick_down()) begin
                if (retries_rem != 8'd0) begin
                  retries_rem = retries_rem - 8'd1;
                  ph = mas_pkg::PH_SENDING;
                end else begin
                  ph = mas_pkg::PH_FAILED;
                  tick_cnt = fail_ticks;
                  o.notice = mas_pkg::NOTE_FAIL;
                end
              end
            end
            mas_pkg::PH_ACKED, mas_pkg::PH_FAILED: begin
              // hold only runs while the screen is up
              if (screen_up) begin
                if (tick_down()) begin
                  screen_up = 1'b0;
                  ph = mas_pkg::PH_IDLE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      mas_pkg::ACT_SEND: begin
        pend_src = my_addr;
        pend_dst = r.broadcast ? bc_addr : r.dest_id;
        pend_msg = msg_seq;
        msg_seq = msg_seq + 8'd1;
        if (msg_seq == 8'd0) seq_wrapped = 1'b1;
        bc_send = r.broadcast;
        retries_rem = retry_lim;
        repeat_pending = r.broadcast;
        ph = mas_pkg::PH_SENDING;
        screen_up = 1'b1;
      end
      mas_pkg::ACT_CANCEL: begin
        if (screen_up) begin
          ph = mas_pkg::PH_IDLE;
          screen_up = 1'b0;
        end
      end
      mas_pkg::ACT_ACK: begin
        if (ph == mas_pkg::PH_WAIT_ACK && r.frame_receiver_id == pend_src &&
            r.frame_sender_id == pend_dst && r.frame_message_id == pend_msg) begin
          ph = mas_pkg::PH_ACKED;
          tick_cnt = ok_ticks;
          o.notice = mas_pkg::NOTE_OK;
        end
      end
      mas_pkg::ACT_DATA: begin
        if (r.broadcast || r.frame_receiver_id == my_addr) begin
          o.rx_for_me = 1'b1;
          if (!r.broadcast) begin
            ack_dst = r.frame_sender_id;
            ack_seq = r.frame_message_id;
            ack_owed = 1'b1;
          end
        end
      end
      default: ;
    endcase
    o.send_state = ph;
    return o;
  endfunction

  function automatic mas_pkg::req_t make_req(input logic [2:0] act, input logic bc,
                                             input logic [15:0] dest,
                                             input logic [15:0] fsrc,
                                             input logic [15:0] fdst,
                                             input logic [7:0] fmsg);
    mas_pkg::req_t r;
    r.action = act;
    r.broadcast = bc;
    r.dest_id = dest;
    r.frame_sender_id = fsrc;
    r.frame_receiver_id = fdst;
    r.frame_message_id = fmsg;
    return r;
  endfunction

  function automatic logic [15:0] pick_addr();
    int p;
    p = $urandom_range(0, 99);
    if (p < 8) return 16'h0000;
    if (p < 16) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // random request, biased toward sequences that move the sender along
  function automatic mas_pkg::req_t gen_req(input int send_pct);
    mas_pkg::req_t r;
    int p;
    int b;
    r = make_req(mas_pkg::ACT_TICK, 1'($urandom_range(0, 1)), pick_addr(), pick_addr(),
                 pick_addr(), 8'($urandom_range(0, 255)));
    p = $urandom_range(0, 99);
    b = $urandom_range(0, 15);
    if (p < send_pct) begin
      r.action = mas_pkg::ACT_SEND;
      r.broadcast = ($urandom_range(0, 9) < 3);
    end else begin
      p = $urandom_range(0, 99);
      if (p < 55) begin
        r.action = mas_pkg::ACT_TICK;
      end else if (p < 70) begin
        // ack aimed at the pending send, sometimes with one bit off
        r.action = mas_pkg::ACT_ACK;
        r.frame_receiver_id = pend_src;
        r.frame_sender_id = pend_dst;
        r.frame_message_id = pend_msg;
        if ($urandom_range(0, 9) >= 7) begin
          case ($urandom_range(0, 2))
            0: r.frame_receiver_id[b] = ~r.frame_receiver_id[b];
            1: r.frame_sender_id[b] = ~r.frame_sender_id[b];
            default: r.frame_message_id[b % 8] = ~r.frame_message_id[b % 8];
          endcase
        end
      end else if (p < 85) begin
        r.action = mas_pkg::ACT_DATA;
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            r.broadcast = 1'b0;
            r.frame_receiver_id = my_addr;
          end
          6, 7: r.broadcast = 1'b1;
          default: r.broadcast = 1'b0;
        endcase
      end else if (p < 93) begin
        r.action = mas_pkg::ACT_CANCEL;
      end else if (p < 97) begin
        r.action = 3'($urandom_range(ActReservedLo, ActReservedHi));
      end else begin
        r.action = mas_pkg::ACT_ACK;
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (no_idle) return 0;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one request: optional gap, then hold until taken; prediction on acceptance
  task automatic push_req(input mas_pkg::req_t r);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r.frame_message_id, r.frame_receiver_id, r.frame_sender_id,
                     r.dest_id};
    s_axis_tuser <= {r.broadcast, r.action};
    do @(posedge clk_i); while (!s_axis_tready);
    frames_due.push_back(predict_step(r));
  endtask

  // stop sending and let every expected result come back
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (frames_due.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reg(input mas_pkg::reg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      mas_pkg::REG_RADIO_ID:    my_addr = val;
      mas_pkg::REG_BCAST_ID:    bc_addr = val;
      mas_pkg::REG_ACK_TIMEOUT: ack_ticks = val;
      mas_pkg::REG_BCAST_GAP:   gap_ticks = val;
      mas_pkg::REG_MAX_RETRIES: retry_lim = val[7:0];
      mas_pkg::REG_OK_HOLD:     ok_ticks = val;
      mas_pkg::REG_FAIL_HOLD:   fail_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] radio, input logic [15:0] bcast,
                            input logic [15:0] ack_to, input logic [15:0] gap,
                            input logic [15:0] retries, input logic [15:0] ok_hold,
                            input logic [15:0] fail_hold);
    wait_idle();
    write_reg(mas_pkg::REG_RADIO_ID, radio);
    write_reg(mas_pkg::REG_BCAST_ID, bcast);
    write_reg(mas_pkg::REG_ACK_TIMEOUT, ack_to);
    write_reg(mas_pkg::REG_BCAST_GAP, gap);
    write_reg(mas_pkg::REG_MAX_RETRIES, retries);
    write_reg(mas_pkg::REG_OK_HOLD, ok_hold);
    write_reg(mas_pkg::REG_FAIL_HOLD, fail_hold);
  endtask

  task automatic set_short_timers();
    set_config(16'($urandom_range(1, 65534)), pick_addr(), 16'($urandom_range(1, 6)),
               16'($urandom_range(1, 6)), 16'($urandom_range(0, 4)),
               16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)));
  endtask

  task automatic run_random(input int n, input int send_pct);
    for (int i = 0; i < n; i++) begin
      // now and then hold off until the pipe is empty
      if ($urandom_range(0, 99) == 0) wait_idle();
      push_req(gen_req(send_pct));
    end
  endtask

  // corner cases at reset defaults, then with every timer at zero
  task automatic test_directed();
    push_req(make_req(ActReservedHi, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_req(make_req(mas_pkg::ACT_CANCEL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_ACK, 1'b0, 16'h0000, 16'hFFFF, 16'h0001, 8'h00));
    push_req(make_req(mas_pkg::ACT_DATA, 1'b0, 16'h0000, 16'hFFFF, my_addr, 8'hFF));
    push_req(make_req(mas_pkg::ACT_SEND, 1'b0, 16'hFFFF, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_ACK, 1'b0, 16'h0000, pend_dst, pend_src,
                      pend_msg ^ 8'h01));
    push_req(make_req(mas_pkg::ACT_ACK, 1'b0, 16'h0000, pend_dst, pend_src, pend_msg));
    push_req(make_req(mas_pkg::ACT_CANCEL, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_DATA, 1'b1, 16'h0000, 16'h1234, 16'h0000, 8'h5A));
    push_req(make_req(mas_pkg::ACT_DATA, 1'b0, 16'h0000, 16'h1234, 16'h0000, 8'h5A));
    push_req(make_req(mas_pkg::ACT_SEND, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    // a new send while the broadcast gap runs restarts the sender
    push_req(make_req(mas_pkg::ACT_SEND, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF, 8'hFF));
    push_req(make_req(ActReservedLo, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF));

    set_config(16'hFFFE, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    push_req(make_req(mas_pkg::ACT_SEND, 1'b0, 16'h1234, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_SEND, 1'b1, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
    push_req(make_req(mas_pkg::ACT_TICK, 1'b0, 16'h0000, 16'h0000, 16'h0000, 8'h00));
  endtask

  task automatic test_short_timers();
    set_short_timers();
    run_random(200, 10);
  endtask

  task automatic test_long_timers();
    set_config(16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h00FF, 16'hFFFF, 16'hFFFF);
    run_random(120, 10);
  endtask

  task automatic test_min_timers();
    set_config(16'h0001, 16'h0000, 16'h0001, 16'h0001, 16'h0000, 16'h0001, 16'h0001);
    run_random(150, 10);
  endtask

  task automatic test_zero_timers();
    set_config(16'($urandom_range(1, 65534)), pick_addr(), 16'h0000, 16'h0000,
               16'($urandom_range(0, 2)), 16'h0000, 16'h0000);
    run_random(150, 10);
  endtask

  task automatic test_back_to_back();
    set_short_timers();
    no_idle = 1'b1;
    run_random(150, 10);
    wait_idle();
    no_idle = 1'b0;
  endtask

  task automatic test_send_heavy();
    set_short_timers();
    run_random(150, 35);
  endtask

  // keep sending until the message id counter rolls over
  task automatic test_id_wrap();
    set_short_timers();
    while (!seq_wrapped) begin
      push_req(make_req(mas_pkg::ACT_SEND, 1'($urandom_range(0, 1)), pick_addr(),
                        pick_addr(), pick_addr(), 8'($urandom_range(0, 255))));
      push_req(make_req(mas_pkg::ACT_TICK, 1'($urandom_range(0, 1)), pick_addr(),
                        pick_addr(), pick_addr(), 8'($urandom_range(0, 255))));
    end
    run_random(20, 10);
  endtask

  task automatic finish_run();
    wait_idle();
    repeat (10) @(posedge clk_i);
    if (err_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  endtask

  initial begin
    sender_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_short_timers();
    test_long_timers();
    test_min_timers();
    test_zero_timers();
    test_back_to_back();
    test_send_heavy();
    test_id_wrap();
    finish_run();
  end

  // result side back-pressure: mostly short stalls, a few long ones
  always @(negedge clk_i) begin
    if (no_idle) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 70) begin
        m_axis_tready <= 1'b1;
      end else if (stall_roll < 96) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // compare each taken result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    mas_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (frames_due.size() == 0) begin
        note_mismatch("result with none pending", m_axis_tdata[31:0], 32'd0);
      end else begin
        want = frames_due.pop_front();
        if (m_axis_tuser[1:0] != want.tx_kind)
          note_mismatch("tx_kind", 32'(m_axis_tuser[1:0]), 32'(want.tx_kind));
        if (m_axis_tdata[15:0] != want.tx_sender_id)
          note_mismatch("tx_sender_id", 32'(m_axis_tdata[15:0]),
                        32'(want.tx_sender_id));
        if (m_axis_tdata[31:16] != want.tx_receiver_id)
          note_mismatch("tx_receiver_id", 32'(m_axis_tdata[31:16]),
                        32'(want.tx_receiver_id));
        if (m_axis_tdata[39:32] != want.tx_message_id)
          note_mismatch("tx_message_id", 32'(m_axis_tdata[39:32]),
                        32'(want.tx_message_id));
        if (m_axis_tdata[42:40] != want.send_state)
          note_mismatch("send_state", 32'(m_axis_tdata[42:40]), 32'(want.send_state));
        if (m_axis_tdata[44:43] != want.notice)
          note_mismatch("notice", 32'(m_axis_tdata[44:43]), 32'(want.notice));
        if (m_axis_tdata[45] != want.rx_for_me)
          note_mismatch("rx_for_me", 32'(m_axis_tdata[45]), 32'(want.rx_for_me));
        if (m_axis_tdata[mas_pkg::OutDataW-1:46] != '0)
          note_mismatch("pad bits", 32'(m_axis_tdata[mas_pkg::OutDataW-1:46]), 32'd0);
      end
    end
  end

  // give up when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= StuckLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

endmodule
